@@ src/tsch_pkg.sv @@
// Shared package for the task table scheduler.
// Holds slot codes, event kinds, the slot record and controller/datapath structs.
// No dependencies.
`default_nettype none
package tsch_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int IDX_W     = $clog2(NUM_SLOTS + 1);
  localparam int CNT_W     = SLOT_W;

  // Slot states.
  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_READY    = 3'd1;
  localparam logic [2:0] ST_RUNNING  = 3'd2;
  localparam logic [2:0] ST_BLOCKED  = 3'd3;
  localparam logic [2:0] ST_SLEEPING = 3'd4;
  localparam logic [2:0] ST_WAITING  = 3'd5;

  // Event kinds.
  localparam logic [2:0] K_CREATE  = 3'd0;
  localparam logic [2:0] K_BLOCK   = 3'd1;
  localparam logic [2:0] K_UNBLOCK = 3'd2;
  localparam logic [2:0] K_SLEEP   = 3'd3;
  localparam logic [2:0] K_WAKEUP  = 3'd4;
  localparam logic [2:0] K_SCHED   = 3'd5;

  // Configuration register indexes.
  localparam logic REG_TICK_MS   = 1'b0;
  localparam logic REG_IDLE_SLOT = 1'b1;

  // Read address sources.
  localparam logic [1:0] SRC_CNT  = 2'd0;
  localparam logic [1:0] SRC_IDX  = 2'd1;
  localparam logic [1:0] SRC_RUN  = 2'd2;
  localparam logic [1:0] SRC_NEXT = 2'd3;

  // Datapath actions.
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_BLK    = 3'd1;
  localparam logic [2:0] ACT_SLP    = 3'd2;
  localparam logic [2:0] ACT_SEL    = 3'd3;
  localparam logic [2:0] ACT_OLD    = 3'd4;
  localparam logic [2:0] ACT_NEW    = 3'd5;
  localparam logic [2:0] ACT_COMMIT = 3'd6;
  localparam logic [2:0] ACT_RESULT = 3'd7;

  typedef struct packed {
    logic [2:0]  state;
    logic [31:0] ticks;
    logic [7:0]  prio;
  } slot_t;

  typedef struct packed {
    logic             load;
    logic             div_start;
    logic             rd;
    logic [1:0]       rd_src;
    logic             scan;
    logic [2:0]       act;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic       div_busy;
    logic       run_slot;
    logic       next_slot;
    logic       blk_sched;
    logic       out_free;
    logic [2:0] kind;
  } status_t;

endpackage
`default_nettype wire

@@ src/tsch_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/tsch_div.sv @@
// Restoring divider, one quotient bit per cycle, for sleep durations.
// No package dependencies.
`default_nettype none
module tsch_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [9:0]  divisor,
  output      logic        busy,
  output      logic [31:0] quotient
);

  logic [5:0]  cnt;
  logic [9:0]  rem;
  logic [10:0] trial;
  logic [10:0] diff;

  // One trial subtraction per cycle.
  assign trial = {rem, quotient[31]};
  assign diff  = trial - {1'b0, divisor};
  assign busy  = (cnt != 6'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (start) begin
      cnt <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= 10'd0;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem      <= diff[9:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= trial[9:0];
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ src/tsch_ctrl.sv @@
// Controller state machine of the task table scheduler.
// Depends on tsch_pkg; drives commands into tsch_dp and reads its status.
`default_nettype none
module tsch_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire logic [2:0]        kind,
  input  wire tsch_pkg::status_t status,
  output      tsch_pkg::cmd_t    cmd,
  output      logic              item_stall
);
  import tsch_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_SCAN_END = 4'd2;
  localparam logic [3:0] S_SEL      = 4'd3;
  localparam logic [3:0] S_OLD_RD   = 4'd4;
  localparam logic [3:0] S_OLD_WR   = 4'd5;
  localparam logic [3:0] S_NEW_GO   = 4'd6;
  localparam logic [3:0] S_NEW_WR   = 4'd7;
  localparam logic [3:0] S_COMMIT   = 4'd8;
  localparam logic [3:0] S_RESULT   = 4'd9;
  localparam logic [3:0] S_BLK_RD   = 4'd10;
  localparam logic [3:0] S_BLK_WR   = 4'd11;
  localparam logic [3:0] S_DIV_GO   = 4'd12;
  localparam logic [3:0] S_DIV_WAIT = 4'd13;
  localparam logic [3:0] S_SLP_RD   = 4'd14;
  localparam logic [3:0] S_SLP_WR   = 4'd15;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  assign item_stall = (state != S_IDLE);

  // State and scan counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next    = state;
    cnt_next      = '0;
    cmd           = '0;
    cmd.cnt       = cnt;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load = 1'b1;
          case (kind)
            K_CREATE, K_WAKEUP, K_SCHED: state_next = S_SCAN;
            K_BLOCK, K_UNBLOCK:          state_next = S_BLK_RD;
            K_SLEEP:                     state_next = S_DIV_GO;
            default:                     state_next = S_RESULT;
          endcase
        end
      end
      S_SCAN: begin
        cmd.rd     = 1'b1;
        cmd.rd_src = SRC_CNT;
        cmd.scan   = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == CNT_W'(NUM_SLOTS - 1)) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        if (status.kind == K_CREATE || status.kind == K_WAKEUP) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        cmd.act    = ACT_SEL;
        state_next = status.run_slot ? S_OLD_RD : S_NEW_GO;
      end
      S_OLD_RD: begin
        cmd.rd     = 1'b1;
        cmd.rd_src = SRC_RUN;
        state_next = S_OLD_WR;
      end
      S_OLD_WR: begin
        cmd.act    = ACT_OLD;
        state_next = S_NEW_GO;
      end
      S_NEW_GO: begin
        if (status.next_slot) begin
          cmd.rd     = 1'b1;
          cmd.rd_src = SRC_NEXT;
          state_next = S_NEW_WR;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_NEW_WR: begin
        cmd.act    = ACT_NEW;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.act    = ACT_COMMIT;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.act    = ACT_RESULT;
          state_next = S_IDLE;
        end
      end
      S_BLK_RD: begin
        cmd.rd     = 1'b1;
        cmd.rd_src = SRC_IDX;
        state_next = S_BLK_WR;
      end
      S_BLK_WR: begin
        cmd.act    = ACT_BLK;
        state_next = status.blk_sched ? S_SCAN : S_RESULT;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_next = status.run_slot ? S_SLP_RD : S_SCAN;
        end
      end
      S_SLP_RD: begin
        cmd.rd     = 1'b1;
        cmd.rd_src = SRC_RUN;
        state_next = S_SLP_WR;
      end
      S_SLP_WR: begin
        cmd.act    = ACT_SLP;
        state_next = S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ src/tsch_dp.sv @@
// Datapath of the task table scheduler: slot table, running index, divider,
// scan bookkeeping and result register. Depends on tsch_pkg, tsch_ram, tsch_div.
`default_nettype none
module tsch_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tsch_pkg::cmd_t    cmd,
  output      tsch_pkg::status_t status,
  input  wire logic              cfg_write_en,
  input  wire logic              cfg_index,
  input  wire logic [9:0]        cfg_data,
  input  wire logic [2:0]        kind,
  input  wire logic [5:0]        task_index,
  input  wire logic              block_reason,
  input  wire logic [7:0]        priority_req,
  input  wire logic [31:0]       sleep_ms,
  input  wire logic [31:0]       now,
  output      logic              result_valid,
  input  wire logic              result_stall,
  output      logic [6:0]        next_task,
  output      logic              switched,
  output      logic [5:0]        created_slot,
  output      logic              table_full
);
  import tsch_pkg::*;

  // Configuration registers.
  logic [9:0]        tick_ms;
  logic [5:0]        idle_slot;

  // Latched event.
  logic [2:0]        k_q;
  logic [5:0]        idx_q;
  logic              reason_q;
  logic [7:0]        prio_q;
  logic [31:0]       ms_q;
  logic [31:0]       now_q;

  logic [IDX_W-1:0]  running;
  logic [IDX_W-1:0]  run_prev;
  logic [IDX_W-1:0]  next_sel;
  logic              found;
  logic [SLOT_W-1:0] best;
  logic [31:0]       best_tk;
  logic [SLOT_W-1:0] created;

  logic [SLOT_W-1:0] raddr;
  logic [SLOT_W-1:0] rd_addr_q;
  logic              chk_q;
  logic              vld_q;
  logic [NUM_SLOTS-1:0] slot_vld;
  logic [$bits(slot_t)-1:0] rdata;
  slot_t             d;
  slot_t             wdata;
  logic              we;

  logic              div_busy;
  logic [31:0]       quo;
  logic [9:0]        divisor;
  logic [31:0]       nap;

  logic              idx_ok;
  logic              is_sched_kind;

  assign divisor = (tick_ms == 10'd0) ? 10'd1 : tick_ms;
  assign nap     = (quo == 32'd0) ? 32'd1 : quo;
  assign d       = vld_q ? slot_t'(rdata) : '0;
  assign idx_ok  = ({1'b0, idx_q} < IDX_W'(NUM_SLOTS));
  assign is_sched_kind = (k_q == K_BLOCK) || (k_q == K_SLEEP) || (k_q == K_SCHED);

  // Status toward the controller.
  always_comb begin
    status.div_busy  = div_busy;
    status.run_slot  = (running < IDX_W'(NUM_SLOTS));
    status.next_slot = (next_sel < IDX_W'(NUM_SLOTS));
    status.blk_sched = (k_q == K_BLOCK) && idx_ok && (d.state != ST_FREE)
                       && ({1'b0, idx_q} == running);
    status.out_free  = !result_valid || !result_stall;
    status.kind      = k_q;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms   <= 10'd10;
      idle_slot <= 6'd0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_TICK_MS:   tick_ms   <= cfg_data;
        REG_IDLE_SLOT: idle_slot <= cfg_data[5:0];
        default:       tick_ms   <= tick_ms;
      endcase
    end
  end

  // Event latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_q    <= task_index;
      reason_q <= block_reason;
      prio_q   <= priority_req;
      ms_q     <= sleep_ms;
      now_q    <= now;
      run_prev <= running;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_q <= K_SCHED;
    end else if (cmd.load) begin
      k_q <= kind;
    end
  end

  // Read address selection and read-side bookkeeping.
  always_comb begin
    case (cmd.rd_src)
      SRC_CNT:  raddr = cmd.cnt;
      SRC_IDX:  raddr = idx_q[SLOT_W-1:0];
      SRC_RUN:  raddr = running[SLOT_W-1:0];
      default:  raddr = next_sel[SLOT_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_addr_q <= raddr;
      vld_q     <= slot_vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_q <= 1'b0;
    end else begin
      chk_q <= cmd.rd && cmd.scan;
    end
  end

  // Slot writes; each write goes to the slot read just before.
  always_comb begin
    we    = 1'b0;
    wdata = d;
    case (cmd.act)
      ACT_BLK: begin
        we = idx_ok && (d.state != ST_FREE);
        if (k_q == K_BLOCK) begin
          wdata.state = reason_q ? ST_WAITING : ST_BLOCKED;
        end else begin
          wdata.state = ST_READY;
        end
      end
      ACT_SLP: begin
        we          = 1'b1;
        wdata.state = ST_SLEEPING;
        wdata.ticks = now_q + nap;
      end
      ACT_OLD: begin
        we = 1'b1;
        if (d.state == ST_RUNNING) begin
          wdata.state = ST_READY;
        end
        if (d.ticks == 32'd0) begin
          wdata.ticks = {24'd0, d.prio};
        end
      end
      ACT_NEW: begin
        we          = 1'b1;
        wdata.state = ST_RUNNING;
      end
      default: begin
        if (chk_q && k_q == K_CREATE && !found && d.state == ST_FREE) begin
          we          = 1'b1;
          wdata.state = ST_READY;
          wdata.prio  = prio_q;
          wdata.ticks = {24'd0, prio_q};
        end else if (chk_q && k_q == K_WAKEUP && d.state == ST_SLEEPING
                     && d.ticks <= now_q) begin
          we          = 1'b1;
          wdata.state = ST_READY;
          wdata.ticks = 32'd0;
        end
      end
    endcase
  end

  // Valid bits: a slot never written reads as all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (we) begin
      slot_vld[rd_addr_q] <= 1'b1;
    end
  end

  // Scan tracking: first free slot for create, best ready slot for schedule.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found   <= 1'b0;
      created <= '0;
    end else if (chk_q) begin
      if (k_q == K_CREATE) begin
        if (!found && d.state == ST_FREE) begin
          found   <= 1'b1;
          created <= rd_addr_q;
        end
      end else if (is_sched_kind) begin
        if (d.state == ST_READY && {1'b0, rd_addr_q} != running
            && (!found || best_tk < d.ticks)) begin
          found   <= 1'b1;
          best    <= rd_addr_q;
          best_tk <= d.ticks;
        end
      end
    end
  end

  // Selection of the next running task.
  always_ff @(posedge clk) begin
    if (cmd.act == ACT_SEL) begin
      if (found) begin
        next_sel <= {1'b0, best};
      end else if ({1'b0, idle_slot} < IDX_W'(NUM_SLOTS)) begin
        next_sel <= {1'b0, idle_slot};
      end else begin
        next_sel <= running;
      end
    end
  end

  // Running index.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= IDX_W'(NUM_SLOTS);
    end else if (cmd.act == ACT_COMMIT) begin
      running <= next_sel;
    end
  end

  // Result register; holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.act == ACT_RESULT) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act == ACT_RESULT) begin
      next_task    <= 7'(running);
      switched     <= (running != run_prev);
      created_slot <= 6'(created);
      table_full   <= (k_q == K_CREATE) && !found;
    end
  end

  tsch_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (rd_addr_q),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  tsch_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (ms_q),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quo)
  );

endmodule
`default_nettype wire

@@ src/task_table_scheduler_top.sv @@
// Task table scheduler: a 64-slot task table with a round of scheduling events.
// Top level; depends on tsch_pkg, tsch_ctrl and tsch_dp.
//
// Usage: one event is transferred on the item channel (item_valid high,
// item_stall low) and exactly one result is transferred on the result
// channel. The block works on one event at a time; item_stall is high from
// the cycle after a transfer until the cycle after the event's result is
// loaded into the output register, so the next transfer can come in the cycle
// after that load. A result held by a stalled receiver lets one more event in,
// whose result then waits, with the input stalled, until the register frees.
// Steps from transfer to result: unknown kinds go straight to the result;
// unblock and block of a task that is not running read and write its slot;
// create and wakeup walk over all 64 slots, one table read per cycle; schedule
// walks them and writes back the running slot, if any, and the next one; block
// of the running task and sleep (bit-serial divider first) end in a schedule.
// Reset empties the table through per-slot valid bits at once, sets the
// running index to the boot context (64), tick_ms to 10 and idle_slot to 0.
// Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at once;
// the user must make them while no event is in work; the block does not enforce it.
`default_nettype none
module task_table_scheduler_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_index,
  input  wire logic [9:0]  cfg_data,
  input  wire logic        item_valid,
  output      logic        item_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [5:0]  task_index,
  input  wire logic        block_reason,
  input  wire logic [7:0]  priority_req,
  input  wire logic [31:0] sleep_ms,
  input  wire logic [31:0] now,
  output      logic        result_valid,
  input  wire logic        result_stall,
  output      logic [6:0]  next_task,
  output      logic        switched,
  output      logic [5:0]  created_slot,
  output      logic        table_full
);
  import tsch_pkg::*;

  cmd_t    cmd;
  status_t status;

  tsch_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .kind       (kind),
    .status     (status),
    .cmd        (cmd),
    .item_stall (item_stall)
  );

  tsch_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .task_index   (task_index),
    .block_reason (block_reason),
    .priority_req (priority_req),
    .sleep_ms     (sleep_ms),
    .now          (now),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .next_task    (next_task),
    .switched     (switched),
    .created_slot (created_slot),
    .table_full   (table_full)
  );

  // An accepted event always keeps the input closed in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input open right after a transfer");

  // A result is only loaded when the output register can take it.
  a_result_room: assert property (@(posedge clk) disable iff (rst)
    cmd.act == ACT_RESULT |-> status.out_free)
    else $error("result loaded over a pending one");

  // A new result appears only from a result load.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.act == ACT_RESULT))
    else $error("result valid without a load");

endmodule
`default_nettype wire
